FILE: hw/rtl/mrfe_pkg.sv
`default_nettype none

package mrfe_pkg;

  // default register capacity of a read reply
  localparam int MAX_REGS_DEF = 32;

  // depth of the request queue between front and back (power of two)
  localparam int QDEPTH = 2;

  // input kinds
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // result kinds
  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_WORD   = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_READ_OK   = 3'd0;
  localparam logic [2:0] ST_WRITE_OK  = 3'd1;
  localparam logic [2:0] ST_CRC_BAD   = 3'd2;
  localparam logic [2:0] ST_WRONG_SLV = 3'd3;
  localparam logic [2:0] ST_OTHER_FN  = 3'd4;
  localparam logic [2:0] ST_MALFORMED = 3'd5;

  // function codes
  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // classified request held in the queue
  typedef struct packed {
    logic        is_req;
    logic [7:0]  slave;
    logic [7:0]  func_code;
    logic [15:0] reg_address;
    logic [15:0] req_value;
    logic [7:0]  rx_byte;
    logic        frame_end;
  } cmd_t;

  // reflected crc-16 over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mrfe_front.sv
`default_nettype none

module mrfe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic          kind,
  input  wire logic [7:0]    slave,
  input  wire logic [7:0]    func_code,
  input  wire logic [15:0]   reg_address,
  input  wire logic [15:0]   req_value,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          frame_end,
  output logic               q_valid,
  output mrfe_pkg::cmd_t     q_cmd,
  input  wire logic          q_pop
);
  import mrfe_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t            entries [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;
  logic            do_push;
  logic            do_pop;
  cmd_t            cmd_in;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_cmd   = entries[rd_ptr];

  // classify the incoming item
  always_comb begin
    cmd_in.is_req      = (kind == KIND_REQ);
    cmd_in.slave       = slave;
    cmd_in.func_code   = func_code;
    cmd_in.reg_address = reg_address;
    cmd_in.req_value   = req_value;
    cmd_in.rx_byte     = rx_byte;
    cmd_in.frame_end   = frame_end && (kind == KIND_RESP);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mrfe_back.sv
`default_nettype none

module mrfe_back #(
  parameter int MAX_REGS = mrfe_pkg::MAX_REGS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire mrfe_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [1:0]         out_kind,
  output logic [7:0]         tx_byte,
  output logic [5:0]         reg_index,
  output logic [15:0]        reg_value,
  output logic [2:0]         status,
  output logic               last
);
  import mrfe_pkg::*;

  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam logic [7:0] LEN_MAX  = 8'(2 * MAX_REGS + 5);
  localparam logic [6:0] REGS_LIM = 7'(MAX_REGS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REQ     = 3'd1;
  localparam logic [2:0] S_EVAL    = 3'd2;
  localparam logic [2:0] S_WRD_RD  = 3'd3;
  localparam logic [2:0] S_WRD_OUT = 3'd4;
  localparam logic [2:0] S_STATUS  = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [7:0]  expected_slave;
  logic [15:0] crc_rx;
  logic [7:0]  byte_counter;
  logic [7:0]  resp_slave;
  logic [7:0]  resp_function;
  logic [7:0]  resp_byte_count;
  logic [15:0] tail_bytes;
  logic [7:0]  hi_hold;
  logic [47:0] frame;
  logic [2:0]  tx_idx;
  logic [15:0] crc_tx;
  logic [2:0]  st_reg;
  logic [5:0]  word_cnt;
  logic        out_valid;

  logic [15:0] mem [MAX_REGS];
  logic [15:0] mem_q;

  logic        out_free;
  logic        take_byte;
  logic [7:0]  k;
  logic [6:0]  idx;
  logic        wr_en;
  logic [7:0]  tx_sel;
  logic        emit;
  logic [1:0]  e_kind;
  logic [7:0]  e_tx;
  logic [5:0]  e_idx;
  logic [15:0] e_val;
  logic [2:0]  e_st;
  logic        e_last;
  logic [2:0]  st_eval;
  logic        go_words;
  logic [6:0]  nwords;
  logic        last_word;

  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign take_byte = q_pop && !q_cmd.is_req;

  // word store addressing for data bytes
  assign k     = byte_counter - 8'd3;
  assign idx   = k[7:1];
  assign wr_en = take_byte && (byte_counter >= 8'd3) && (idx < REGS_LIM) && k[0];

  assign nwords    = resp_byte_count[7:1];
  assign last_word = ({1'b0, word_cnt} == (nwords - 7'd1));

  always_comb begin
    case (tx_idx)
      3'd0:    tx_sel = frame[47:40];
      3'd1:    tx_sel = frame[39:32];
      3'd2:    tx_sel = frame[31:24];
      3'd3:    tx_sel = frame[23:16];
      3'd4:    tx_sel = frame[15:8];
      3'd5:    tx_sel = frame[7:0];
      3'd6:    tx_sel = crc_tx[7:0];
      default: tx_sel = crc_tx[15:8];
    endcase
  end

  // frame checks: length, crc, slave, function
  always_comb begin
    go_words = 1'b0;
    if (byte_counter < 8'd4 || byte_counter > LEN_MAX) begin
      st_eval = ST_MALFORMED;
    end else if (tail_bytes != {crc_rx[7:0], crc_rx[15:8]}) begin
      st_eval = ST_CRC_BAD;
    end else if (resp_slave != expected_slave) begin
      st_eval = ST_WRONG_SLV;
    end else if (resp_function == FUNC_READ) begin
      if (({1'b0, byte_counter} != ({1'b0, resp_byte_count} + 9'd5)) ||
          resp_byte_count[0]) begin
        st_eval = ST_MALFORMED;
      end else begin
        st_eval  = ST_READ_OK;
        go_words = (nwords != 7'd0);
      end
    end else if (resp_function == FUNC_WRITE) begin
      st_eval = (byte_counter == 8'd8) ? ST_WRITE_OK : ST_MALFORMED;
    end else begin
      st_eval = ST_OTHER_FN;
    end
  end

  always_comb begin
    emit   = 1'b0;
    e_kind = OUT_TX;
    e_tx   = '0;
    e_idx  = '0;
    e_val  = '0;
    e_st   = '0;
    e_last = 1'b0;
    unique case (state)
      S_REQ: begin
        emit   = out_free;
        e_tx   = tx_sel;
        e_last = (tx_idx == 3'd7);
      end
      S_WRD_OUT: begin
        emit   = out_free;
        e_kind = OUT_WORD;
        e_idx  = word_cnt;
        e_val  = mem_q;
      end
      S_STATUS: begin
        emit   = out_free;
        e_kind = OUT_STATUS;
        e_st   = st_reg;
        e_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          if (q_cmd.is_req) begin
            state_next = S_REQ;
          end else if (q_cmd.frame_end) begin
            state_next = S_EVAL;
          end
        end
      end
      S_REQ: begin
        if (out_free && tx_idx == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      S_EVAL:   state_next = go_words ? S_WRD_RD : S_STATUS;
      S_WRD_RD: state_next = S_WRD_OUT;
      S_WRD_OUT: begin
        if (out_free) begin
          state_next = last_word ? S_STATUS : S_WRD_RD;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // word store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx[AW-1:0]] <= {hi_hold, q_cmd.rx_byte};
    end
    if (state == S_WRD_RD) begin
      mem_q <= mem[word_cnt[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= e_kind;
      tx_byte   <= e_tx;
      reg_index <= e_idx;
      reg_value <= e_val;
      status    <= e_st;
      last      <= e_last;
    end
    if (q_pop && q_cmd.is_req) begin
      frame <= {q_cmd.slave, q_cmd.func_code, q_cmd.reg_address, q_cmd.req_value};
    end
    if (take_byte && byte_counter >= 8'd3 && !k[0]) begin
      hi_hold <= q_cmd.rx_byte;
    end
    if (state == S_EVAL) begin
      st_reg <= st_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      expected_slave  <= '0;
      crc_rx          <= CRC_INIT;
      byte_counter    <= '0;
      resp_slave      <= '0;
      resp_function   <= '0;
      resp_byte_count <= '0;
      tail_bytes      <= '0;
      tx_idx          <= '0;
      crc_tx          <= CRC_INIT;
      word_cnt        <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (q_pop && q_cmd.is_req) begin
        expected_slave  <= q_cmd.slave;
        crc_tx          <= CRC_INIT;
        tx_idx          <= '0;
        crc_rx          <= CRC_INIT;
        byte_counter    <= '0;
        resp_slave      <= '0;
        resp_function   <= '0;
        resp_byte_count <= '0;
        tail_bytes      <= '0;
      end

      if (take_byte) begin
        if (byte_counter >= 8'd2) begin
          crc_rx <= crc_byte(crc_rx, tail_bytes[15:8]);
        end
        tail_bytes <= {tail_bytes[7:0], q_cmd.rx_byte};
        if (byte_counter == 8'd0) begin
          resp_slave <= q_cmd.rx_byte;
        end else if (byte_counter == 8'd1) begin
          resp_function <= q_cmd.rx_byte;
        end else if (byte_counter == 8'd2) begin
          resp_byte_count <= q_cmd.rx_byte;
        end
        if (byte_counter != 8'hFF) begin
          byte_counter <= byte_counter + 8'd1;
        end
      end

      if (state == S_REQ && out_free) begin
        if (tx_idx < 3'd6) begin
          crc_tx <= crc_byte(crc_tx, tx_sel);
        end
        tx_idx <= tx_idx + 3'd1;
      end

      if (state == S_EVAL) begin
        word_cnt <= '0;
      end
      if (state == S_WRD_OUT && out_free && !last_word) begin
        word_cnt <= word_cnt + 6'd1;
      end

      // frame closed: receive side back to its reset state
      if (state == S_STATUS && out_free) begin
        crc_rx          <= CRC_INIT;
        byte_counter    <= '0;
        resp_slave      <= '0;
        resp_function   <= '0;
        resp_byte_count <= '0;
        tail_bytes      <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/modbus_rtu_master_frame_engine_unit.sv
`default_nettype none

// channel   direction  handshake     payload
// request   in         push / full   kind slave func_code reg_address req_value
//                                    rx_byte frame_end
// result    out        pop / empty   out_kind tx_byte reg_index reg_value status last
//
// a send request leaves the queue, then goes out one tx byte per cycle while the result
// register is free, the crc advancing one byte per emitted byte
// a response byte is taken while the back is idle; a frame end goes through the checks,
// then per register word a store read (registered) and an output, and then the status
// rst is synchronous and active high; the word store is not cleared
// the input queue keeps taking requests, until full, while the result register waits on pop

module modbus_rtu_master_frame_engine_unit #(
  parameter int MAX_REGS = mrfe_pkg::MAX_REGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind,
  input  wire logic [7:0]  slave,
  input  wire logic [7:0]  func_code,
  input  wire logic [15:0] reg_address,
  input  wire logic [15:0] req_value,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind,
  output logic [7:0]       tx_byte,
  output logic [5:0]       reg_index,
  output logic [15:0]      reg_value,
  output logic [2:0]       status,
  output logic             last
);
  import mrfe_pkg::*;

  // classified request leaving the front queue
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // front: accepts and classifies requests into a short queue
  mrfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .slave       (slave),
    .func_code   (func_code),
    .reg_address (reg_address),
    .req_value   (req_value),
    .rx_byte     (rx_byte),
    .frame_end   (frame_end),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  // back: frame builder, response decoder, word store and result register
  mrfe_back #(
    .MAX_REGS (MAX_REGS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_kind  (out_kind),
    .tx_byte   (tx_byte),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: bench/mrfe_frame_checker.sv
`default_nettype none

module mrfe_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic        kind,
  input  wire logic [7:0]  slave,
  input  wire logic [7:0]  func_code,
  input  wire logic [15:0] reg_address,
  input  wire logic [15:0] req_value,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_end,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [1:0]  out_kind,
  input  wire logic [7:0]  tx_byte,
  input  wire logic [5:0]  reg_index,
  input  wire logic [15:0] reg_value,
  input  wire logic [2:0]  status,
  input  wire logic        last,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import mrfe_pkg::*;

  localparam int REG_CAP = MAX_REGS_DEF;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [5:0]  reg_index;
    logic [15:0] reg_value;
    logic [2:0]  status;
    logic        last;
  } engine_result_t;

  engine_result_t awaited[$];
  engine_result_t got;
  engine_result_t want;

  // receive side of the engine
  logic [7:0]  exp_slave;
  logic [15:0] rx_crc;
  logic [7:0]  rx_count;
  logic [7:0]  rx_slave;
  logic [7:0]  rx_func;
  logic [7:0]  rx_bcount;
  logic [15:0] rx_tail;
  logic [15:0] word_mem [REG_CAP];

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic clear_receive();
    rx_crc    = CRC_INIT;
    rx_count  = 8'd0;
    rx_slave  = 8'd0;
    rx_func   = 8'd0;
    rx_bcount = 8'd0;
    rx_tail   = 16'd0;
  endtask

  task automatic predict_engine_output(input logic k, input logic [7:0] s,
                                       input logic [7:0] f, input logic [15:0] a,
                                       input logic [15:0] v, input logic [7:0] b,
                                       input logic fe);
    logic [7:0]     fr [8];
    logic [15:0]    c;
    logic [15:0]    crc_want;
    logic [2:0]     st;
    engine_result_t r;
    int             p;
    int             len;
    int             bc;
    int             idx;
    if (k == KIND_REQ) begin
      fr[0] = s;
      fr[1] = f;
      fr[2] = a[15:8];
      fr[3] = a[7:0];
      fr[4] = v[15:8];
      fr[5] = v[7:0];
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) c = crc_step(c, fr[i]);
      // crc goes out low byte first
      fr[6] = c[7:0];
      fr[7] = c[15:8];
      for (int i = 0; i < 8; i++) begin
        r = '0;
        r.out_kind = OUT_TX;
        r.tx_byte  = fr[i];
        r.last     = (i == 7);
        awaited.push_back(r);
      end
      exp_slave = s;
      clear_receive();
    end else begin
      p = rx_count;
      // crc lags two bytes so it ends up covering all but the tail
      if (p >= 2) rx_crc = crc_step(rx_crc, rx_tail[15:8]);
      rx_tail = {rx_tail[7:0], b};
      if (p == 0) begin
        rx_slave = b;
      end else if (p == 1) begin
        rx_func = b;
      end else if (p == 2) begin
        rx_bcount = b;
      end else begin
        idx = (p - 3) >> 1;
        if (idx < REG_CAP) begin
          if (((p - 3) % 2) == 1) begin
            word_mem[idx][7:0] = b;
          end else begin
            word_mem[idx][15:8] = b;
          end
        end
      end
      if (rx_count != 8'hFF) rx_count = rx_count + 8'd1;
      if (fe) begin
        len = rx_count;
        crc_want = {rx_crc[7:0], rx_crc[15:8]};
        if (len < 4 || len > 2 * REG_CAP + 5) begin
          st = ST_MALFORMED;
        end else if (rx_tail != crc_want) begin
          st = ST_CRC_BAD;
        end else if (rx_slave != exp_slave) begin
          st = ST_WRONG_SLV;
        end else if (rx_func == FUNC_READ) begin
          bc = rx_bcount;
          if (len != bc + 5 || (bc % 2) != 0) begin
            st = ST_MALFORMED;
          end else begin
            for (int w = 0; w < bc / 2; w++) begin
              r = '0;
              r.out_kind  = OUT_WORD;
              r.reg_index = 6'(w);
              r.reg_value = word_mem[w];
              awaited.push_back(r);
            end
            st = ST_READ_OK;
          end
        end else if (rx_func == FUNC_WRITE) begin
          st = (len == 8) ? ST_WRITE_OK : ST_MALFORMED;
        end else begin
          st = ST_OTHER_FN;
        end
        r = '0;
        r.out_kind = OUT_STATUS;
        r.status   = st;
        r.last     = 1'b1;
        awaited.push_back(r);
        clear_receive();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      exp_slave = 8'd0;
      clear_receive();
      awaited.delete();
      pending      <= 0;
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (push && !full) begin
        predict_engine_output(kind, slave, func_code, reg_address, req_value, rx_byte,
                              frame_end);
      end
      if (pop && !empty) begin
        got = {out_kind, tx_byte, reg_index, reg_value, status, last};
        results_seen <= results_seen + 1;
        if (awaited.size() == 0) begin
          $display("%0t: result with none expected: kind=%0d tx=%02h idx=%0d val=%04h st=%0d last=%0b",
                   $time, got.out_kind, got.tx_byte, got.reg_index, got.reg_value,
                   got.status, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected kind=%0d tx=%02h idx=%0d val=%04h st=%0d last=%0b",
                     $time, want.out_kind, want.tx_byte, want.reg_index, want.reg_value,
                     want.status, want.last);
            $display("%0t:                  actual kind=%0d tx=%02h idx=%0d val=%04h st=%0d last=%0b",
                     $time, got.out_kind, got.tx_byte, got.reg_index, got.reg_value,
                     got.status, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= awaited.size();
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_modbus_rtu_master_frame_engine_unit.sv
`default_nettype none

module tb_modbus_rtu_master_frame_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mrfe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 28;

  // ways a random response goes wrong
  typedef enum int {
    BAD_CRC, BAD_SLAVE, ODD_FUNC, ODD_COUNT, LEN_MISMATCH,
    WRITE_LEN, SHORT_FRAME, OVERLONG, NOISE, CUT_OFF
  } broken_kind_t;

  // every block input known from time zero
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic        kind        = KIND_REQ;
  logic [7:0]  slave       = 8'd0;
  logic [7:0]  func_code   = 8'd0;
  logic [15:0] reg_address = 16'd0;
  logic [15:0] req_value   = 16'd0;
  logic [7:0]  rx_byte     = 8'd0;
  logic        frame_end   = 1'b0;
  logic        pop         = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  out_kind;
  logic [7:0]  tx_byte;
  logic [5:0]  reg_index;
  logic [15:0] reg_value;
  logic [2:0]  status;
  logic        last;

  int fail_count;
  int pending;
  int results_seen;

  // idling knobs, in percent of cycles
  int snd_idle  = 0;
  int rcv_stall = 0;

  // long receiver hold-off, started by the stimulus
  logic hold_go = 1'b0;
  logic hold_off;

  int items_sent    = 0;
  int requests_sent = 0;
  int frames_sent   = 0;
  int cycle_cnt;
  int start_items;

  // response frame under construction
  logic [7:0] frame_buf[$];

  modbus_rtu_master_frame_engine_unit i_dut (.*);

  mrfe_frame_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: random stalls, or held low through a hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_off) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  // hold-off counted here so the sender keeps pushing meanwhile
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still awaited", cycle_cnt, pending);
    $display("[modbus_rtu_master_frame_engine_unit] ERROR");
    $finish;
  end

  // hold the request until it is taken, then maybe idle for a while
  task automatic push_and_idle();
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    while ($urandom_range(0, 99) < snd_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // send request; unused byte fields carry noise
  task automatic send_request(input logic [7:0] s, input logic [7:0] f,
                              input logic [15:0] a, input logic [15:0] v);
    kind        <= KIND_REQ;
    slave       <= s;
    func_code   <= f;
    reg_address <= a;
    req_value   <= v;
    rx_byte     <= 8'($urandom);
    frame_end   <= 1'($urandom);
    push_and_idle();
    requests_sent++;
  endtask

  // one received byte; request fields carry noise
  task automatic send_byte(input logic [7:0] b, input logic fe);
    kind        <= KIND_RESP;
    slave       <= 8'($urandom);
    func_code   <= 8'($urandom);
    reg_address <= 16'($urandom);
    req_value   <= 16'($urandom);
    rx_byte     <= b;
    frame_end   <= fe;
    push_and_idle();
  endtask

  task automatic start_frame(input logic [7:0] s, input logic [7:0] f);
    frame_buf.delete();
    frame_buf.push_back(s);
    frame_buf.push_back(f);
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endtask

  // modbus crc over the frame so far, low byte first on the wire
  task automatic append_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) begin
      c = c ^ {8'h00, frame_buf[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  // whole frame, idle gap flagged on the last byte
  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
    frames_sent++;
  endtask

  // drop push and wait for the result side to catch up
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one request followed by a reply, mostly well formed
  task automatic random_exchange();
    int           flavor;
    int           n;
    logic         cut;
    logic [7:0]   slv;
    logic [7:0]   fn;
    logic [15:0]  addr;
    logic [15:0]  val;
    broken_kind_t pick;
    slv    = 8'($urandom);
    addr   = 16'($urandom);
    val    = 16'($urandom);
    flavor = $urandom_range(0, 99);
    cut    = 1'b0;
    if (flavor < 70) begin
      fn = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
    end else begin
      fn = 8'($urandom);
    end
    send_request(slv, fn, addr, val);
    if (flavor < 70 && fn == FUNC_READ) begin
      // mostly short replies, now and then up to the full capacity
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_REGS_DEF) : $urandom_range(0, 4);
      start_frame(slv, FUNC_READ);
      frame_buf.push_back(8'(2 * n));
      add_random(2 * n);
      append_crc();
    end else if (flavor < 70) begin
      // write echo
      start_frame(slv, FUNC_WRITE);
      frame_buf.push_back(addr[15:8]);
      frame_buf.push_back(addr[7:0]);
      frame_buf.push_back(val[15:8]);
      frame_buf.push_back(val[7:0]);
      append_crc();
    end else begin
      pick = broken_kind_t'($urandom_range(0, 9));
      case (pick)
        BAD_CRC: begin
          start_frame(slv, FUNC_WRITE);
          add_random(4);
          append_crc();
          n = $urandom_range(0, frame_buf.size() - 1);
          frame_buf[n] = frame_buf[n] ^ 8'(1 << $urandom_range(0, 7));
        end
        BAD_SLAVE: begin
          start_frame(slv ^ 8'($urandom_range(1, 255)), FUNC_WRITE);
          add_random(4);
          append_crc();
        end
        ODD_FUNC: begin
          do fn = 8'($urandom); while (fn == FUNC_READ || fn == FUNC_WRITE);
          start_frame(slv, fn);
          add_random($urandom_range(0, 6));
          append_crc();
        end
        ODD_COUNT: begin
          n = 2 * $urandom_range(0, 4) + 1;
          start_frame(slv, FUNC_READ);
          frame_buf.push_back(8'(n));
          add_random(n);
          append_crc();
        end
        LEN_MISMATCH: begin
          n = $urandom_range(0, 4);
          start_frame(slv, FUNC_READ);
          frame_buf.push_back(8'(2 * n));
          add_random(2 * n + $urandom_range(1, 3));
          append_crc();
        end
        WRITE_LEN: begin
          do n = $urandom_range(0, 8); while (n == 4);
          start_frame(slv, FUNC_WRITE);
          add_random(n);
          append_crc();
        end
        SHORT_FRAME: begin
          frame_buf.delete();
          add_random($urandom_range(1, 3));
        end
        OVERLONG: begin
          // valid crc, but one byte or more past the longest reply
          start_frame(slv, FUNC_READ);
          frame_buf.push_back(8'($urandom));
          add_random($urandom_range(65, 70));
          append_crc();
        end
        NOISE: begin
          frame_buf.delete();
          add_random($urandom_range(4, 12));
        end
        default: begin
          // reply broken off, the next request must clear it
          frame_buf.delete();
          add_random($urandom_range(1, 5));
          foreach (frame_buf[i]) send_byte(frame_buf[i], 1'b0);
          cut = 1'b1;
        end
      endcase
    end
    if (!cut) send_frame();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes on requests
    send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
    send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    // good read reply with an all-ones word
    start_frame(8'hFF, FUNC_READ);
    frame_buf.push_back(8'h02);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'hFF);
    append_crc();
    send_frame();
    // lone byte closing a frame: too short
    send_byte(8'h00, 1'b1);
    frames_sent++;
    // unknown function from the right slave
    start_frame(8'hFF, 8'h00);
    append_crc();
    send_frame();
    // good crc from the wrong slave
    start_frame(8'h00, FUNC_WRITE);
    append_crc();
    send_frame();
    // corrupted crc byte
    start_frame(8'hFF, FUNC_WRITE);
    append_crc();
    frame_buf[3] = frame_buf[3] ^ 8'h80;
    send_frame();
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle  = 0;
          rcv_stall = 0;
          // receiver holds off while requests keep coming
          hold_go   = 1'b1;
        end
        1: begin
          snd_idle  = 65;
          rcv_stall = 0;
        end
        2: begin
          snd_idle  = 0;
          rcv_stall = 65;
        end
        default: begin
          snd_idle  = 14;
          rcv_stall = 14;
        end
      endcase
      start_items = items_sent;
      while (items_sent - start_items < PHASE_ITEMS) random_exchange();
      // sender pauses until every result is out
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d send requests and %0d response frames over %0d input items",
             requests_sent, frames_sent, items_sent);
    $display("%0d results compared, %0d mismatching", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[modbus_rtu_master_frame_engine_unit] OK");
    end else begin
      $display("[modbus_rtu_master_frame_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/mrfe_pkg.sv
hw/rtl/mrfe_front.sv
hw/rtl/mrfe_back.sv
hw/rtl/modbus_rtu_master_frame_engine_unit.sv
bench/mrfe_frame_checker.sv
bench/tb_modbus_rtu_master_frame_engine_unit.sv
